### rtl/cfim_pkg.sv
// shared types, codes and constants of the command frame motor interlock
package cfim_pkg;

	// frame layout
	localparam int FRAME_BYTES = 6;
	localparam int FB_STORED   = FRAME_BYTES - 1;
	localparam int CNT_W       = $clog2(FRAME_BYTES);
	localparam int FB_IDX_W    = $clog2(FB_STORED);

	// decoupling queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// operation codes on the input channel
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_GAP  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// register indexes
	localparam logic [2:0] REG_END_MARKER = 3'd0;
	localparam logic [2:0] REG_SERVO_GAIN = 3'd1;
	localparam logic [2:0] REG_MOTOR_GAIN = 3'd2;
	localparam logic [2:0] REG_REV_CODE   = 3'd3;
	localparam logic [2:0] REG_DIST_LIMIT = 3'd4;
	localparam logic [2:0] REG_SUP_LIMIT  = 3'd5;
	localparam logic [2:0] REG_LINK_TMO   = 3'd6;

	// register reset values
	localparam logic [7:0]  END_MARKER_RST = 8'd126;
	localparam logic [7:0]  SERVO_GAIN_RST = 8'd20;
	localparam logic [9:0]  MOTOR_GAIN_RST = 10'd500;
	localparam logic [7:0]  REV_CODE_RST   = 8'd33;
	localparam logic [7:0]  DIST_LIMIT_RST = 8'd20;
	localparam logic [11:0] SUP_LIMIT_RST  = 12'd3000;
	localparam logic [15:0] LINK_TMO_RST   = 16'd50;

	// state reset values
	localparam logic [15:0] SERVO_CMD_RST   = 16'd1200;
	localparam logic [7:0]  STORED_DIST_RST = 8'd10;
	localparam logic [15:0] WDOG_MAX        = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_GAP,
		KIND_TICK,
		KIND_NONE
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  rx_byte;
		logic [7:0]  distance_cm;
		logic [11:0] supply_sample;
	} cfim_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cfim_qstat_t;

	typedef struct packed {
		logic [7:0]  end_marker;
		logic [7:0]  servo_gain;
		logic [9:0]  motor_gain;
		logic [7:0]  reverse_code;
		logic [7:0]  distance_limit;
		logic [11:0] supply_limit;
		logic [15:0] link_timeout_ticks;
	} cfim_cfg_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [15:0] drive_pwm;
		logic [15:0] lift_pwm;
		logic [15:0] servo_pwm;
		logic        drive_fwd_pin;
		logic        drive_rev_pin;
		logic        lift_up_pin;
		logic        lift_down_pin;
		logic        led_obstacle;
		logic        led_link;
		logic        led_supply;
	} cfim_result_t;

endpackage

### rtl/cfim_front.sv
// input side: takes words, classifies the operation and pushes into the queue
module cfim_front (
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           operation,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           distance_cm,
	input  logic [11:0]          supply_sample,
	input  cfim_pkg::cfim_qstat_t qstat,
	output logic                 push,
	output cfim_pkg::cfim_item_t  item
);
	import cfim_pkg::*;

	// stall only while the queue has no room
	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	// operation decode
	always_comb begin
		unique case (operation)
			OP_BYTE: item.kind = KIND_BYTE;
			OP_GAP:  item.kind = KIND_GAP;
			OP_TICK: item.kind = KIND_TICK;
			default: item.kind = KIND_NONE;
		endcase
		item.rx_byte       = rx_byte;
		item.distance_cm   = distance_cm;
		item.supply_sample = supply_sample;
	end

endmodule

### rtl/cfim_queue.sv
// short queue of classified words between front and back
module cfim_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cfim_pkg::cfim_item_t  push_item,
	input  logic                  pop,
	output cfim_pkg::cfim_item_t  head_item,
	output cfim_pkg::cfim_qstat_t qstat
);
	import cfim_pkg::*;

	cfim_item_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head_item   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

### rtl/cfim_back.sv
// execution side: frame assembly, command latch, watchdog, interlock, result register
module cfim_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfim_pkg::cfim_cfg_t    cfg,
	input  cfim_pkg::cfim_item_t   item,
	input  cfim_pkg::cfim_qstat_t  qstat,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output cfim_pkg::cfim_result_t res
);
	import cfim_pkg::*;

	// architectural state
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       frame_bytes_q [FB_STORED];
	logic [15:0]      servo_cmd_q, drive_cmd_q, lift_cmd_q;
	logic [7:0]       drive_dir_q, lift_dir_q, stored_dist_q;
	logic [15:0]      wdog_q;
	logic             link_lost_q;
	logic [15:0]      o_drive_q, o_lift_q;
	logic             o_dfwd_q, o_drev_q, o_lup_q, o_ldown_q;
	logic             led_obs_q, led_link_q, led_sup_q;

	// result register
	logic             out_valid_q;
	cfim_result_t     res_q;

	// next state
	logic [CNT_W-1:0] n_byte_count;
	logic [15:0]      n_servo_cmd, n_drive_cmd, n_lift_cmd;
	logic [7:0]       n_drive_dir, n_lift_dir, n_stored_dist;
	logic [15:0]      n_wdog;
	logic             n_link_lost;
	logic [15:0]      n_o_drive, n_o_lift;
	logic             n_dfwd, n_drev, n_lup, n_ldown;
	logic             n_led_obs, n_led_link, n_led_sup;
	logic             n_tx_valid;
	logic [7:0]       n_tx_byte;

	logic [CNT_W-1:0]    cnt_eff;
	logic                frame_last;
	logic                store_byte;
	logic [FB_IDX_W-1:0] fb_idx;
	logic [15:0]         servo_prod;
	logic [17:0]         drive_prod, lift_prod;
	logic                obstacle, low_sup, lost_now;

	// execute the head word whenever the result register can take it
	assign pop       = !qstat.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// frame position of the incoming byte
	assign cnt_eff    = (byte_count_q >= CNT_W'(FRAME_BYTES)) ? '0 : byte_count_q;
	assign frame_last = (cnt_eff == CNT_W'(FB_STORED));
	assign fb_idx     = FB_IDX_W'(cnt_eff);
	assign store_byte = pop && (item.kind == KIND_BYTE) && !frame_last;

	// command scaling, three independent products
	assign servo_prod = frame_bytes_q[0] * cfg.servo_gain;
	assign drive_prod = frame_bytes_q[1] * cfg.motor_gain;
	assign lift_prod  = frame_bytes_q[2] * cfg.motor_gain;

	// tick conditions
	assign n_wdog   = (wdog_q == WDOG_MAX) ? wdog_q : wdog_q + 16'd1;
	assign lost_now = link_lost_q || (n_wdog >= cfg.link_timeout_ticks);
	assign obstacle = (stored_dist_q <= cfg.distance_limit);
	assign low_sup  = (item.supply_sample <= cfg.supply_limit);

	always_comb begin
		n_byte_count  = byte_count_q;
		n_servo_cmd   = servo_cmd_q;
		n_drive_cmd   = drive_cmd_q;
		n_lift_cmd    = lift_cmd_q;
		n_drive_dir   = drive_dir_q;
		n_lift_dir    = lift_dir_q;
		n_stored_dist = stored_dist_q;
		n_link_lost   = link_lost_q;
		n_o_drive     = o_drive_q;
		n_o_lift      = o_lift_q;
		n_dfwd        = o_dfwd_q;
		n_drev        = o_drev_q;
		n_lup         = o_lup_q;
		n_ldown       = o_ldown_q;
		n_led_obs     = led_obs_q;
		n_led_link    = led_link_q;
		n_led_sup     = led_sup_q;
		n_tx_valid    = 1'b0;
		n_tx_byte     = '0;
		unique case (item.kind)
			KIND_BYTE: begin
				if (frame_last) begin
					n_tx_valid   = 1'b1;
					n_tx_byte    = stored_dist_q;
					n_byte_count = '0;
					n_link_lost  = 1'b0;
					if (item.rx_byte == cfg.end_marker) begin
						n_servo_cmd = servo_prod;
						n_drive_cmd = drive_prod[15:0];
						n_lift_cmd  = lift_prod[15:0];
						n_drive_dir = frame_bytes_q[3];
						n_lift_dir  = frame_bytes_q[4];
					end
				end else begin
					n_byte_count = cnt_eff + 1'b1;
				end
			end
			KIND_GAP: begin
				if (byte_count_q != '0) begin
					n_byte_count = '0;
					n_link_lost  = 1'b0;
				end
			end
			KIND_TICK: begin
				n_link_lost = lost_now;
				if (!lost_now && !obstacle && !low_sup) begin
					n_o_drive  = drive_cmd_q;
					n_o_lift   = lift_cmd_q;
					n_dfwd     = (drive_dir_q != cfg.reverse_code);
					n_drev     = (drive_dir_q == cfg.reverse_code);
					n_lup      = (lift_dir_q != cfg.reverse_code);
					n_ldown    = (lift_dir_q == cfg.reverse_code);
					n_led_obs  = 1'b0;
					n_led_link = 1'b0;
					n_led_sup  = 1'b0;
				end else begin
					n_o_drive = '0;
					n_o_lift  = '0;
					n_dfwd    = 1'b0;
					n_drev    = 1'b0;
					n_lup     = 1'b0;
					n_ldown   = 1'b0;
					if (low_sup)  n_led_sup  = 1'b1;
					if (lost_now) n_led_link = 1'b1;
					if (obstacle) n_led_obs  = 1'b1;
				end
				if (item.distance_cm != '0) n_stored_dist = item.distance_cm;
			end
			default: begin
			end
		endcase
	end

	// watchdog clears on frame end or on a gap that drops a partial frame, counts on ticks
	logic [15:0] wdog_next;
	always_comb begin
		wdog_next = wdog_q;
		if (item.kind == KIND_TICK) begin
			wdog_next = n_wdog;
		end else if ((item.kind == KIND_BYTE && frame_last) ||
		             (item.kind == KIND_GAP && byte_count_q != '0)) begin
			wdog_next = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			servo_cmd_q   <= SERVO_CMD_RST;
			drive_cmd_q   <= '0;
			lift_cmd_q    <= '0;
			drive_dir_q   <= '0;
			lift_dir_q    <= '0;
			stored_dist_q <= STORED_DIST_RST;
			wdog_q        <= '0;
			link_lost_q   <= 1'b0;
			o_drive_q     <= '0;
			o_lift_q      <= '0;
			o_dfwd_q      <= 1'b0;
			o_drev_q      <= 1'b0;
			o_lup_q       <= 1'b0;
			o_ldown_q     <= 1'b0;
			led_obs_q     <= 1'b0;
			led_link_q    <= 1'b0;
			led_sup_q     <= 1'b0;
		end else if (pop) begin
			byte_count_q  <= n_byte_count;
			servo_cmd_q   <= n_servo_cmd;
			drive_cmd_q   <= n_drive_cmd;
			lift_cmd_q    <= n_lift_cmd;
			drive_dir_q   <= n_drive_dir;
			lift_dir_q    <= n_lift_dir;
			stored_dist_q <= n_stored_dist;
			wdog_q        <= wdog_next;
			link_lost_q   <= n_link_lost;
			o_drive_q     <= n_o_drive;
			o_lift_q      <= n_o_lift;
			o_dfwd_q      <= n_dfwd;
			o_drev_q      <= n_drev;
			o_lup_q       <= n_lup;
			o_ldown_q     <= n_ldown;
			led_obs_q     <= n_led_obs;
			led_link_q    <= n_led_link;
			led_sup_q     <= n_led_sup;
		end
	end

	// frame byte store, written before it is read
	always_ff @(posedge clk) begin
		if (store_byte) frame_bytes_q[fb_idx] <= item.rx_byte;
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.tx_valid      <= n_tx_valid;
			res_q.tx_byte       <= n_tx_byte;
			res_q.drive_pwm     <= n_o_drive;
			res_q.lift_pwm      <= n_o_lift;
			res_q.servo_pwm     <= n_servo_cmd;
			res_q.drive_fwd_pin <= n_dfwd;
			res_q.drive_rev_pin <= n_drev;
			res_q.lift_up_pin   <= n_lup;
			res_q.lift_down_pin <= n_ldown;
			res_q.led_obstacle  <= n_led_obs;
			res_q.led_link      <= n_led_link;
			res_q.led_supply    <= n_led_sup;
		end
	end

endmodule

### rtl/command_frame_motor_interlock.sv
// top level: register port, front, queue and back of the command frame motor interlock
// an accepted word is written to the queue, then executed into the registered result word
// throughput: one word per cycle while the output is not stalled, set by the execute stage in the back part
// a four-entry queue lets input and output stall independently
// reset: asynchronous, active low; registers take their defaults, frame state and
// watchdog clear, servo command 1200, stored distance 10, no clearing pass
module command_frame_motor_interlock (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  distance_cm,
	input  logic [11:0] supply_sample,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic [15:0] drive_pwm,
	output logic [15:0] lift_pwm,
	output logic [15:0] servo_pwm,
	output logic        drive_fwd_pin,
	output logic        drive_rev_pin,
	output logic        lift_up_pin,
	output logic        lift_down_pin,
	output logic        led_obstacle,
	output logic        led_link,
	output logic        led_supply
);
	import cfim_pkg::*;

	cfim_cfg_t    cfg_q;
	cfim_item_t   push_item;
	cfim_item_t   head_item;
	cfim_qstat_t  qstat;
	cfim_result_t res;
	logic         push;
	logic         pop;
	logic         cfg_wr;
	logic [2:0]   reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_marker         <= END_MARKER_RST;
			cfg_q.servo_gain         <= SERVO_GAIN_RST;
			cfg_q.motor_gain         <= MOTOR_GAIN_RST;
			cfg_q.reverse_code       <= REV_CODE_RST;
			cfg_q.distance_limit     <= DIST_LIMIT_RST;
			cfg_q.supply_limit       <= SUP_LIMIT_RST;
			cfg_q.link_timeout_ticks <= LINK_TMO_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_END_MARKER: cfg_q.end_marker         <= pwdata[7:0];
				REG_SERVO_GAIN: cfg_q.servo_gain         <= pwdata[7:0];
				REG_MOTOR_GAIN: cfg_q.motor_gain         <= pwdata[9:0];
				REG_REV_CODE:   cfg_q.reverse_code       <= pwdata[7:0];
				REG_DIST_LIMIT: cfg_q.distance_limit     <= pwdata[7:0];
				REG_SUP_LIMIT:  cfg_q.supply_limit       <= pwdata[11:0];
				REG_LINK_TMO:   cfg_q.link_timeout_ticks <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_END_MARKER: prdata = {24'd0, cfg_q.end_marker};
			REG_SERVO_GAIN: prdata = {24'd0, cfg_q.servo_gain};
			REG_MOTOR_GAIN: prdata = {22'd0, cfg_q.motor_gain};
			REG_REV_CODE:   prdata = {24'd0, cfg_q.reverse_code};
			REG_DIST_LIMIT: prdata = {24'd0, cfg_q.distance_limit};
			REG_SUP_LIMIT:  prdata = {20'd0, cfg_q.supply_limit};
			REG_LINK_TMO:   prdata = {16'd0, cfg_q.link_timeout_ticks};
			default:        prdata = '0;
		endcase
	end

	cfim_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.rx_byte       (rx_byte),
		.distance_cm   (distance_cm),
		.supply_sample (supply_sample),
		.qstat         (qstat),
		.push          (push),
		.item          (push_item)
	);

	cfim_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.qstat     (qstat)
	);

	cfim_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (head_item),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// result word fields
	assign tx_valid      = res.tx_valid;
	assign tx_byte       = res.tx_byte;
	assign drive_pwm     = res.drive_pwm;
	assign lift_pwm      = res.lift_pwm;
	assign servo_pwm     = res.servo_pwm;
	assign drive_fwd_pin = res.drive_fwd_pin;
	assign drive_rev_pin = res.drive_rev_pin;
	assign lift_up_pin   = res.lift_up_pin;
	assign lift_down_pin = res.lift_down_pin;
	assign led_obstacle  = res.led_obstacle;
	assign led_link      = res.led_link;
	assign led_supply    = res.led_supply;

`ifndef SYNTHESIS
	// reply byte is zero unless a reply is sent
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == 8'd0)
		else $error("tx_byte nonzero without tx_valid");

	// bridge legs never both driven
	a_bridge_legs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_fwd_pin && drive_rev_pin) && !(lift_up_pin && lift_down_pin))
		else $error("both bridge legs high");

	// a running drive motor always has a direction leg selected
	a_drive_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_pwm != 16'd0 |-> drive_fwd_pin || drive_rev_pin)
		else $error("drive pwm without direction");

	// a running lift motor means no fault led is lit
	a_lift_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lift_pwm != 16'd0 |-> !led_obstacle && !led_link && !led_supply)
		else $error("lift pwm while faulted");
`endif

endmodule

### tb/sv/command_frame_motor_interlock_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the command frame motor interlock: directed table, then random traffic
module command_frame_motor_interlock_tb;
	import cfim_pkg::*;

	// code outside the defined operations, must leave all state alone
	localparam logic [1:0] OP_RESERVED = 2'd3;
	// frame positions of the two direction bytes
	localparam int DRIVE_DIR_POS = 3;
	localparam int LIFT_DIR_POS  = 4;
	localparam int N_DIRECTED    = 26;
	localparam int RANDOM_PHASES = 6;
	localparam int WORDS_PER_PHASE = 290;
	localparam cfim_result_t BY_PREDICTOR = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_BYTE;
	logic [7:0]  rx_byte = '0;
	logic [7:0]  distance_cm = '0;
	logic [11:0] supply_sample = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic [15:0] drive_pwm;
	logic [15:0] lift_pwm;
	logic [15:0] servo_pwm;
	logic        drive_fwd_pin;
	logic        drive_rev_pin;
	logic        lift_up_pin;
	logic        lift_down_pin;
	logic        led_obstacle;
	logic        led_link;
	logic        led_supply;

	command_frame_motor_interlock dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.rx_byte(rx_byte), .distance_cm(distance_cm), .supply_sample(supply_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.tx_valid(tx_valid), .tx_byte(tx_byte),
		.drive_pwm(drive_pwm), .lift_pwm(lift_pwm), .servo_pwm(servo_pwm),
		.drive_fwd_pin(drive_fwd_pin), .drive_rev_pin(drive_rev_pin),
		.lift_up_pin(lift_up_pin), .lift_down_pin(lift_down_pin),
		.led_obstacle(led_obstacle), .led_link(led_link), .led_supply(led_supply)
	);

	// clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of registers and state
	cfim_cfg_t    cfg;
	int           bytes_held;
	logic [7:0]   frame_buf [FRAME_BYTES];
	logic [15:0]  servo_cmd, drive_cmd, lift_cmd;
	logic [7:0]   drive_dir, lift_dir, dist_held;
	logic [15:0]  wdog_ticks;
	logic         link_down;
	cfim_result_t held_outputs;

	// expected result words in order, oldest at the front
	cfim_result_t interlock_words_due [$];
	int           fault_count = 0;
	int           gap_pct = 0;
	int           stall_pct = 0;
	int           hold_cycles = 0;

	// directed stimulus; typed expectations only where they are obvious
	typedef struct {
		logic [1:0]   op;
		logic [7:0]   rx;
		logic [7:0]   dist_cm;
		logic [11:0]  sup;
		bit           typed;
		cfim_result_t res;
	} stim_row_t;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// reserved code and idle gap right after reset: nothing moves
		'{OP_RESERVED, 8'd255, 8'd255, 12'd4095, 1'b1,
			'{servo_pwm: SERVO_CMD_RST, default: '0}},
		'{OP_GAP, 8'd0, 8'd0, 12'd0, 1'b1, '{servo_pwm: SERVO_CMD_RST, default: '0}},
		// reset distance is below the limit, invalid reading keeps it
		'{OP_TICK, 8'd0, 8'd0, 12'd4095, 1'b1,
			'{servo_pwm: SERVO_CMD_RST, led_obstacle: 1'b1, default: '0}},
		'{OP_TICK, 8'd0, 8'd255, 12'd0, 1'b1,
			'{servo_pwm: SERVO_CMD_RST, led_obstacle: 1'b1, led_supply: 1'b1, default: '0}},
		// all good: zero commands, forward legs, leds cleared
		'{OP_TICK, 8'd0, 8'd0, 12'd4095, 1'b1,
			'{servo_pwm: SERVO_CMD_RST, drive_fwd_pin: 1'b1, lift_up_pin: 1'b1, default: '0}},
		// good frame, drive reversed, products truncated
		'{OP_BYTE, 8'd10, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd200, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd131, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd33, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd0, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd126, 8'd0, 12'd0, 1'b1,
			'{tx_valid: 1'b1, tx_byte: 8'd255, servo_pwm: 16'd200, drive_fwd_pin: 1'b1,
			lift_up_pin: 1'b1, default: '0}},
		'{OP_TICK, 8'd0, 8'd21, 12'd3001, 1'b0, BY_PREDICTOR},
		'{OP_TICK, 8'd0, 8'd20, 12'd3001, 1'b0, BY_PREDICTOR},
		'{OP_TICK, 8'd0, 8'd0, 12'd3001, 1'b0, BY_PREDICTOR},
		'{OP_TICK, 8'd0, 8'd100, 12'd3000, 1'b0, BY_PREDICTOR},
		// frame with wrong end marker: reply only
		'{OP_BYTE, 8'd255, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd255, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd255, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd255, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd255, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd0, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		// partial frame with a reserved code inside, dropped by a gap
		'{OP_BYTE, 8'd7, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_RESERVED, 8'd7, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_BYTE, 8'd7, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_GAP, 8'd0, 8'd0, 12'd0, 1'b0, BY_PREDICTOR},
		'{OP_TICK, 8'd0, 8'd0, 12'd4095, 1'b0, BY_PREDICTOR}
	};

	// predictor: advance state by one input word and return the result word
	task automatic interlock_step(input logic [1:0] op, input logic [7:0] rx,
		input logic [7:0] dist_cm, input logic [11:0] sup, output cfim_result_t r);
		logic [31:0] product;
		logic        obstacle, low_sup;
		r = held_outputs;
		r.tx_valid = 1'b0;
		r.tx_byte = '0;
		case (op)
			OP_BYTE: begin
				if (bytes_held >= FRAME_BYTES)
					bytes_held = 0;
				frame_buf[bytes_held] = rx;
				bytes_held++;
				if (bytes_held == FRAME_BYTES) begin
					r.tx_valid = 1'b1;
					r.tx_byte = dist_held;
					// latch commands only on matching end marker
					if (frame_buf[FB_STORED] == cfg.end_marker) begin
						product = 32'(frame_buf[0]) * 32'(cfg.servo_gain);
						servo_cmd = product[15:0];
						product = 32'(frame_buf[1]) * 32'(cfg.motor_gain);
						drive_cmd = product[15:0];
						product = 32'(frame_buf[2]) * 32'(cfg.motor_gain);
						lift_cmd = product[15:0];
						drive_dir = frame_buf[DRIVE_DIR_POS];
						lift_dir = frame_buf[LIFT_DIR_POS];
					end
					bytes_held = 0;
					wdog_ticks = '0;
					link_down = 1'b0;
				end
			end
			OP_GAP: begin
				if (bytes_held != 0) begin
					bytes_held = 0;
					wdog_ticks = '0;
					link_down = 1'b0;
				end
			end
			OP_TICK: begin
				if (wdog_ticks != WDOG_MAX)
					wdog_ticks++;
				if (wdog_ticks >= cfg.link_timeout_ticks)
					link_down = 1'b1;
				// decision uses the distance held before this tick
				obstacle = dist_held <= cfg.distance_limit;
				low_sup = sup <= cfg.supply_limit;
				if (!link_down && !obstacle && !low_sup) begin
					held_outputs.drive_pwm = drive_cmd;
					held_outputs.lift_pwm = lift_cmd;
					held_outputs.drive_fwd_pin = drive_dir != cfg.reverse_code;
					held_outputs.drive_rev_pin = drive_dir == cfg.reverse_code;
					held_outputs.lift_up_pin = lift_dir != cfg.reverse_code;
					held_outputs.lift_down_pin = lift_dir == cfg.reverse_code;
					held_outputs.led_obstacle = 1'b0;
					held_outputs.led_link = 1'b0;
					held_outputs.led_supply = 1'b0;
				end else begin
					held_outputs.drive_pwm = '0;
					held_outputs.lift_pwm = '0;
					held_outputs.drive_fwd_pin = 1'b0;
					held_outputs.drive_rev_pin = 1'b0;
					held_outputs.lift_up_pin = 1'b0;
					held_outputs.lift_down_pin = 1'b0;
					if (low_sup)
						held_outputs.led_supply = 1'b1;
					if (link_down)
						held_outputs.led_link = 1'b1;
					if (obstacle)
						held_outputs.led_obstacle = 1'b1;
				end
				if (dist_cm != 0)
					dist_held = dist_cm;
				r = held_outputs;
			end
			default: ;
		endcase
		r.servo_pwm = servo_cmd;
	endtask

	// offer one input word, wait for acceptance, queue its expected result
	task automatic offer_word(input logic [1:0] op, input logic [7:0] rx,
		input logic [7:0] dist_cm, input logic [11:0] sup,
		input bit typed = 1'b0, input cfim_result_t typed_res = BY_PREDICTOR);
		cfim_result_t predicted;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= rx;
		distance_cm <= dist_cm;
		supply_sample <= sup;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		interlock_step(op, rx, dist_cm, sup, predicted);
		interlock_words_due.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	// register write: setup then access cycle, then back to idle
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_END_MARKER: cfg.end_marker = val[7:0];
			REG_SERVO_GAIN: cfg.servo_gain = val[7:0];
			REG_MOTOR_GAIN: cfg.motor_gain = val[9:0];
			REG_REV_CODE:   cfg.reverse_code = val[7:0];
			REG_DIST_LIMIT: cfg.distance_limit = val[7:0];
			REG_SUP_LIMIT:  cfg.supply_limit = val[11:0];
			REG_LINK_TMO:   cfg.link_timeout_ticks = val[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_setting(input cfim_cfg_t s);
		write_reg(REG_END_MARKER, 32'(s.end_marker));
		write_reg(REG_SERVO_GAIN, 32'(s.servo_gain));
		write_reg(REG_MOTOR_GAIN, 32'(s.motor_gain));
		write_reg(REG_REV_CODE, 32'(s.reverse_code));
		write_reg(REG_DIST_LIMIT, 32'(s.distance_limit));
		write_reg(REG_SUP_LIMIT, 32'(s.supply_limit));
		write_reg(REG_LINK_TMO, 32'(s.link_timeout_ticks));
	endtask

	// wait until every expected word is back, then let the pipeline settle
	task automatic drain();
		while (interlock_words_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// distances cluster on the limit, with invalid readings mixed in
	function automatic logic [7:0] pick_distance();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 8'd0;
		if (roll < 4)
			return cfg.distance_limit + 8'($urandom_range(0, 1));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [11:0] pick_supply();
		if ($urandom_range(0, 9) < 3)
			return cfg.supply_limit + 12'($urandom_range(0, 1));
		return 12'($urandom_range(0, 4095));
	endfunction

	// mostly well-formed frames and tick bursts, some broken frames and noise
	task automatic random_traffic(input int target);
		int done, pick, k, n;
		logic [7:0] b;
		done = 0;
		while (done < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				for (k = 0; k < FRAME_BYTES; k++) begin
					b = 8'($urandom_range(0, 255));
					if (k == FB_STORED && $urandom_range(0, 9) < 8)
						b = cfg.end_marker;
					if ((k == DRIVE_DIR_POS || k == LIFT_DIR_POS) && $urandom_range(0, 1))
						b = cfg.reverse_code;
					offer_word(OP_BYTE, b, pick_distance(), pick_supply());
					done++;
					if ($urandom_range(0, 11) == 0) begin
						offer_word(OP_TICK, 8'($urandom), pick_distance(), pick_supply());
						done++;
					end
				end
			end else if (pick < 83) begin
				n = $urandom_range(1, 4);
				repeat (n)
					offer_word(OP_TICK, 8'($urandom), pick_distance(), pick_supply());
				done += n;
			end else if (pick < 92) begin
				// partial frame cut off by a byte gap
				n = $urandom_range(1, FRAME_BYTES - 1);
				repeat (n)
					offer_word(OP_BYTE, 8'($urandom), pick_distance(), pick_supply());
				offer_word(OP_GAP, 8'($urandom), pick_distance(), pick_supply());
				done += n + 1;
			end else if (pick < 95) begin
				// stray bytes that misalign the following frames
				n = $urandom_range(1, 2);
				repeat (n)
					offer_word(OP_BYTE, 8'($urandom), pick_distance(), pick_supply());
				done += n;
			end else if (pick < 98) begin
				offer_word(OP_GAP, 8'($urandom), pick_distance(), pick_supply());
			end else begin
				offer_word(OP_RESERVED, 8'($urandom), pick_distance(), pick_supply());
			end
		end
	endtask

	// receiver: random stall, or a counted hold-off when requested
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endtask

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin : result_check
		cfim_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (interlock_words_due.size() == 0) begin
				$error("result word with no expectation pending");
				fault_count++;
			end else begin
				want = interlock_words_due.pop_front();
				check_field("tx_valid", 16'(want.tx_valid), 16'(tx_valid));
				check_field("tx_byte", 16'(want.tx_byte), 16'(tx_byte));
				check_field("drive_pwm", want.drive_pwm, drive_pwm);
				check_field("lift_pwm", want.lift_pwm, lift_pwm);
				check_field("servo_pwm", want.servo_pwm, servo_pwm);
				check_field("drive_fwd_pin", 16'(want.drive_fwd_pin), 16'(drive_fwd_pin));
				check_field("drive_rev_pin", 16'(want.drive_rev_pin), 16'(drive_rev_pin));
				check_field("lift_up_pin", 16'(want.lift_up_pin), 16'(lift_up_pin));
				check_field("lift_down_pin", 16'(want.lift_down_pin), 16'(lift_down_pin));
				check_field("led_obstacle", 16'(want.led_obstacle), 16'(led_obstacle));
				check_field("led_link", 16'(want.led_link), 16'(led_link));
				check_field("led_supply", 16'(want.led_supply), 16'(led_supply));
			end
		end
	end

	// main sequence: reset, directed table, then random phases under new settings
	initial begin
		cfim_cfg_t s;
		int ph;
		cfg = '{END_MARKER_RST, SERVO_GAIN_RST, MOTOR_GAIN_RST, REV_CODE_RST,
			DIST_LIMIT_RST, SUP_LIMIT_RST, LINK_TMO_RST};
		bytes_held = 0;
		foreach (frame_buf[i])
			frame_buf[i] = '0;
		servo_cmd = SERVO_CMD_RST;
		drive_cmd = '0;
		lift_cmd = '0;
		drive_dir = '0;
		lift_dir = '0;
		dist_held = STORED_DIST_RST;
		wdog_ticks = '0;
		link_down = 1'b0;
		held_outputs = '0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer_word(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].dist_cm,
				directed_rows[i].sup, directed_rows[i].typed, directed_rows[i].res);
		in_valid <= 1'b0;
		drain();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				// low extremes of the gains and codes, high limits, shortest timeout
				0: s = '{8'd0, 8'd0, 10'd0, 8'd0, 8'd255, 12'd4095, 16'd1};
				// high gains and codes, lowest limits, longest timeout
				1: s = '{8'd255, 8'd255, 10'd1023, 8'd255, 8'd0, 12'd0, 16'd65535};
				default: begin
					s.end_marker = 8'($urandom_range(0, 255));
					s.servo_gain = 8'($urandom_range(0, 255));
					s.motor_gain = 10'($urandom_range(0, 1023));
					s.reverse_code = 8'($urandom_range(0, 255));
					s.distance_limit = 8'($urandom_range(0, 60));
					s.supply_limit = 12'($urandom_range(0, 4095));
					s.link_timeout_ticks = 16'($urandom_range(2, 10));
				end
			endcase
			apply_setting(s);
			case (ph % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 57; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 57; end
				default: begin gap_pct = 23; stall_pct = 23; end
			endcase
			// long receiver hold-off so the input side backs up
			if (ph == 1 || ph == 4)
				hold_cycles = 80;
			random_traffic(WORDS_PER_PHASE);
			in_valid <= 1'b0;
			drain();
		end

		repeat (4) @(negedge clk);
		if (fault_count == 0 && interlock_words_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
